/* hw/rtl/multi_queue_linked_list_manager_top_assert.svh */
// Assertion macros shared by the queue manager RTL.
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_TOP_ASSERT_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_TOP_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define MQLLM_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// Check that post holds in the cycle after pre.
`define MQLLM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

/* hw/rtl/mqllm_pkg.sv */
package mqllm_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int NUM_QUEUES = 16;

   localparam int TYPE_W  = 2;
   localparam int QUEUE_W = 4;
   localparam int SLOT_W  = 6;

   localparam int LINK_AW = $clog2(NUM_SLOTS);
   localparam int LINK_W  = SLOT_W + 1;
   localparam int STEP_W  = $clog2(NUM_SLOTS + 1);

   localparam int REQ_FIELDS_W = TYPE_W + QUEUE_W + SLOT_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SLOT_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [TYPE_W-1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_REMOVE  = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } link_type;

   function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
      return int'(s) < NUM_SLOTS;
   endfunction

   function automatic logic queue_ok(input logic [QUEUE_W-1:0] q);
      return int'(q) < NUM_QUEUES;
   endfunction

endpackage

/* hw/rtl/mqllm_ram.sv */
module mqllm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/multi_queue_linked_list_manager_top.sv */
// Sequence: an enqueue goes from accept straight to DONE; a dequeue or remove walks the
// list in CHK at one link memory read per cycle, passes through CLR when a predecessor
// link is patched, and DONE loads the output register once it is free.
// Flow: one item at a time; the next item is taken once the result is registered, and
// a rsp stall holds the result in DONE and so holds back the next item.
// Reset: synchronous, active high; clears sequencer, head valid bits and output valid.
`include "multi_queue_linked_list_manager_top_assert.svh"

module multi_queue_linked_list_manager_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fields from bit 0 up: req_type[1:0], queue_id[5:2], slot[11:6], zero pad
   input  logic [mqllm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fields from bit 0 up: result_slot[5:0], status[6], zero pad
   output logic [mqllm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import mqllm_pkg::*;

   // Sequencer: IDLE takes an item, CHK walks one link per cycle,
   // CLR clears the unlinked slot when a predecessor was patched,
   // DONE hands the result to the output register.
   typedef enum logic [1:0] {S_IDLE, S_CHK, S_CLR, S_DONE} state_type;

   state_type state_ff, state_in;

   // Unpack the request item.
   logic [TYPE_W-1:0]  in_type;
   logic [QUEUE_W-1:0] in_queue;
   logic [SLOT_W-1:0]  in_slot;

   assign in_type  = req_tdata[TYPE_W-1:0];
   assign in_queue = req_tdata[TYPE_W +: QUEUE_W];
   assign in_slot  = req_tdata[TYPE_W + QUEUE_W +: SLOT_W];

   // Per-item working registers.
   logic [TYPE_W-1:0]  op_ff, op_in;
   logic [QUEUE_W-1:0] queue_ff, queue_in;
   logic [SLOT_W-1:0]  target_ff, target_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  prev_ff, prev_in;
   logic               has_prev_ff, has_prev_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic               res_status_ff, res_status_in;

   // Queue heads: small enough to live in flops, read at one address.
   logic [NUM_QUEUES-1:0] head_valid_ff, head_valid_in;
   logic [SLOT_W-1:0]     head_slot_ff [NUM_QUEUES];
   logic [SLOT_W-1:0]     head_slot_in [NUM_QUEUES];

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_free;

   // Link memory port.
   logic               ram_we;
   logic [LINK_AW-1:0] ram_waddr;
   link_type           ram_wdata;
   logic               ram_re;
   logic [LINK_AW-1:0] ram_raddr;
   link_type           ram_rdata;

   mqllm_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      link_type          link;
      logic              advance;
      logic              unlink;
      logic              head_v;
      logic [SLOT_W-1:0] head_s;

      link      = ram_rdata;
      advance   = 1'b0;
      unlink    = 1'b0;
      head_v    = 1'b0;
      head_s    = '0;

      state_in      = state_ff;
      op_in         = op_ff;
      queue_in      = queue_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      has_prev_in   = has_prev_ff;
      steps_in      = steps_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      head_valid_in = head_valid_ff;
      head_slot_in  = head_slot_ff;

      // Drain the output register when the consumer takes the item.
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;

      ram_we    = 1'b0;
      ram_waddr = cur_ff[LINK_AW-1:0];
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cur_ff[LINK_AW-1:0];

      req_tready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = in_type;
               queue_in      = in_queue;
               target_in     = in_slot;
               prev_in       = '0;
               has_prev_in   = 1'b0;
               steps_in      = '0;
               res_slot_in   = '0;
               res_status_in = STATUS_MISS;
               state_in      = S_DONE;
               if (queue_ok(in_queue)) begin
                  head_v = head_valid_ff[in_queue];
                  head_s = head_slot_ff[in_queue];
                  cur_in = head_s;
                  unique case (in_type)
                     REQ_ENQUEUE: begin
                        // Push at the head: the new slot points at the old head.
                        if (slot_ok(in_slot)) begin
                           ram_we                 = 1'b1;
                           ram_waddr              = in_slot[LINK_AW-1:0];
                           ram_wdata.valid        = head_v;
                           ram_wdata.slot         = head_s;
                           head_valid_in[in_queue] = 1'b1;
                           head_slot_in[in_queue]  = in_slot;
                           res_slot_in            = in_slot;
                           res_status_in          = STATUS_DONE;
                        end
                     end
                     REQ_DEQUEUE: begin
                        if (head_v && slot_ok(head_s)) begin
                           ram_re    = 1'b1;
                           ram_raddr = head_s[LINK_AW-1:0];
                           state_in  = S_CHK;
                        end
                     end
                     REQ_REMOVE: begin
                        if (slot_ok(in_slot) && head_v && slot_ok(head_s)) begin
                           ram_re    = 1'b1;
                           ram_raddr = head_s[LINK_AW-1:0];
                           state_in  = S_CHK;
                        end
                     end
                     default: begin
                        // Unknown request: answer a miss.
                     end
                  endcase
               end
            end
         end

         S_CHK: begin
            // ram_rdata holds the link of cur_ff.
            if (op_ff == REQ_DEQUEUE) begin
               advance = (int'(steps_ff) < NUM_SLOTS) && link.valid && slot_ok(link.slot);
               unlink  = !advance;
            end else begin
               if (int'(steps_ff) < NUM_SLOTS) begin
                  if (cur_ff == target_ff) begin
                     unlink = 1'b1;
                  end else begin
                     advance = link.valid && slot_ok(link.slot);
                  end
               end
            end

            if (advance) begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = link.slot;
               steps_in    = steps_ff + 1'b1;
               ram_re      = 1'b1;
               ram_raddr   = link.slot[LINK_AW-1:0];
            end else if (unlink) begin
               res_slot_in   = cur_ff;
               res_status_in = STATUS_DONE;
               if (has_prev_ff) begin
                  // Patch the predecessor now, clear cur next cycle.
                  ram_we    = 1'b1;
                  ram_waddr = prev_ff[LINK_AW-1:0];
                  ram_wdata = link;
                  state_in  = S_CLR;
               end else begin
                  head_valid_in[queue_ff] = link.valid;
                  head_slot_in[queue_ff]  = link.slot;
                  ram_we                  = 1'b1;
                  ram_waddr               = cur_ff[LINK_AW-1:0];
                  ram_wdata               = '0;
                  state_in                = S_DONE;
               end
            end else begin
               // End of list or step limit: remove misses.
               state_in = S_DONE;
            end
         end

         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff[LINK_AW-1:0];
            ram_wdata = '0;
            state_in  = S_DONE;
         end

         S_DONE: begin
            // Hold the result until the output register is free.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      queue_ff      <= queue_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      steps_ff      <= steps_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      head_slot_ff  <= head_slot_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_status_ff, rsp_slot_ff});

   // The link memory never reads and writes in the same cycle.
   `MQLLM_ASSERT_IMPLY(a_ram_port_excl, clock, reset, ram_we, !ram_re)

   // The walk never runs past the pool size.
   `MQLLM_ASSERT_IMPLY(a_step_bound, clock, reset, state_ff == S_CHK,
                       int'(steps_ff) <= NUM_SLOTS)

   // A miss always reports slot zero.
   `MQLLM_ASSERT_IMPLY(a_miss_zero, clock, reset,
                       rsp_valid_ff && (rsp_status_ff == STATUS_MISS), rsp_slot_ff == '0)

   // An accepted item leaves the idle state.
   `MQLLM_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready,
                      state_ff != S_IDLE)

   // A finished item lands in the output register.
   `MQLLM_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == S_DONE) && rsp_free,
                      rsp_valid_ff && (state_ff == S_IDLE))

endmodule
